@@ sv/tcgr_pkg.sv @@
package tcgr_pkg;

	localparam int GLYPH_HEIGHT_DEF = 16;
	localparam int MAX_DIM = 4096;
	localparam int FONT_DEPTH = 4096;
	localparam int CELL_W = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PRINT = 1'b1;

	localparam logic [7:0] CHR_BS = 8'd8;
	localparam logic [7:0] CHR_LF = 8'd10;
	localparam logic [7:0] CHR_CR = 8'd13;

	localparam logic [1:0] KIND_GLYPH = 2'd0;
	localparam logic [1:0] KIND_ERASE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] CFG_ENABLED = 2'd0;
	localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

	localparam logic [12:0] RST_SCREEN_WIDTH = 13'd1024;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;

	typedef struct packed {
		logic op;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] row_bits;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0] pixel_mask;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic enabled;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_GLYPH,
		CMD_ERASE,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t cmd;
		logic [7:0] code;
		logic [3:0] glyph_row;
		logic [7:0] row_bits;
		logic [11:0] x;
		logic [11:0] y;
		logic clr;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROWS,
		BK_CLEAR
	} bk_state_t;

endpackage

@@ sv/tcgr_ram.sv @@
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/tcgr_front.sv @@
module tcgr_front import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	input logic q_full,
	output logic push,
	output cmd_t push_cmd
);

	localparam logic [12:0] GH13 = 13'(GLYPH_HEIGHT);
	localparam logic [11:0] GH12 = 12'(GLYPH_HEIGHT);
	localparam logic [12:0] CW13 = 13'(CELL_W);
	localparam logic [11:0] CW12 = 12'(CELL_W);

	logic [11:0] col_q, line_q;
	logic [12:0] w, h, x1, y1, x2, y2;
	logic [11:0] bx, by, nx, ny;
	logic ovf, accept, is_move, is_print;

	assign item_stall = q_full;
	assign accept = item_valid && !q_full;
	assign is_print = item.op == OP_PRINT;

	always_comb begin
		if (cfg.screen_width < CW13) w = CW13;
		else if (cfg.screen_width > 13'(MAX_DIM)) w = 13'(MAX_DIM);
		else w = cfg.screen_width;
		if (cfg.screen_height < 13'd16) h = 13'd16;
		else if (cfg.screen_height > 13'(MAX_DIM)) h = 13'(MAX_DIM);
		else h = cfg.screen_height;
	end

	always_comb begin
		bx = col_q;
		by = line_q;
		if (col_q >= CW12) begin
			bx = col_q - CW12;
		end else if (line_q >= GH12) begin
			by = line_q - GH12;
			bx = 12'(w - CW13);
		end
	end

	always_comb begin
		is_move = item.char_code inside {CHR_LF, CHR_CR};
		case (item.char_code)
			CHR_LF: begin
				x1 = '0;
				y1 = {1'b0, line_q} + GH13;
			end
			CHR_CR: begin
				x1 = '0;
				y1 = {1'b0, line_q};
			end
			default: begin
				x1 = {1'b0, col_q} + CW13;
				y1 = {1'b0, line_q};
			end
		endcase
		if (x1 + CW13 > w) begin
			x2 = '0;
			y2 = y1 + GH13;
		end else begin
			x2 = x1;
			y2 = y1;
		end
		ovf = (y2 + GH13) > h;
		nx = ovf ? '0 : x2[11:0];
		ny = ovf ? '0 : y2[11:0];
	end

	always_comb begin
		push_cmd.code = item.char_code;
		push_cmd.glyph_row = item.glyph_row;
		push_cmd.row_bits = item.row_bits;
		push_cmd.x = col_q;
		push_cmd.y = line_q;
		push_cmd.clr = ovf;
		push = 1'b0;
		if (!is_print) begin
			push_cmd.cmd = CMD_LOAD;
			push = accept;
		end else if (item.char_code == CHR_BS) begin
			push_cmd.cmd = CMD_ERASE;
			push_cmd.x = bx;
			push_cmd.y = by;
			push_cmd.clr = 1'b0;
			push = accept && cfg.enabled;
		end else if (is_move) begin
			push_cmd.cmd = CMD_CLEAR;
			push = accept && cfg.enabled && ovf;
		end else begin
			push_cmd.cmd = CMD_GLYPH;
			push = accept && cfg.enabled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			line_q <= '0;
		end else if (accept && is_print && cfg.enabled) begin
			if (item.char_code == CHR_BS) begin
				col_q <= bx;
				line_q <= by;
			end else begin
				col_q <= nx;
				line_q <= ny;
			end
		end
	end

endmodule

@@ sv/tcgr_queue.sv @@
module tcgr_queue import tcgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/tcgr_back.sv @@
module tcgr_back import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cmd_t head,
	output logic pop,
	output logic res_valid,
	input logic res_stall,
	output out_item_t res
);

	localparam int RW = $clog2(GLYPH_HEIGHT);
	localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_HEIGHT - 1);
	localparam int AW = $clog2(FONT_DEPTH);

	bk_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [RW-1:0] row_q;

	logic issue, issue_ok, advance, we;
	logic [1:0] kind_i;
	logic [11:0] x_i, y_i;
	logic last_i;

	logic valid_s1, last_s1;
	logic [1:0] kind_s1;
	logic [11:0] x_s1, y_s1;

	logic res_valid_q;
	out_item_t res_q;
	logic [7:0] rdata, mask;

	assign advance = !res_valid_q || !res_stall;
	assign issue_ok = !valid_s1 || advance;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					case (head.cmd)
						CMD_GLYPH, CMD_ERASE: state_d = BK_ROWS;
						CMD_CLEAR: state_d = BK_CLEAR;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_ROWS: begin
				if (issue_ok && row_q == LAST_ROW) state_d = cmd_q.clr ? BK_CLEAR : BK_IDLE;
			end
			BK_CLEAR: begin
				if (issue_ok) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		we = 1'b0;
		issue = 1'b0;
		kind_i = KIND_CLEAR;
		x_i = '0;
		y_i = '0;
		last_i = 1'b1;
		case (state_q)
			BK_IDLE: begin
				pop = q_valid;
				we = q_valid && head.cmd == CMD_LOAD;
			end
			BK_ROWS: begin
				issue = issue_ok;
				kind_i = (cmd_q.cmd == CMD_GLYPH) ? KIND_GLYPH : KIND_ERASE;
				x_i = cmd_q.x;
				y_i = cmd_q.y + 12'(row_q);
				last_i = (row_q == LAST_ROW) && !cmd_q.clr;
			end
			BK_CLEAR: begin
				issue = issue_ok;
			end
			default: begin
			end
		endcase
	end

	tcgr_ram #(
		.WIDTH(8),
		.DEPTH(FONT_DEPTH)
	) u_font (
		.clk(clk),
		.we(we),
		.waddr({head.code, head.glyph_row}),
		.wdata(head.row_bits),
		.re(issue),
		.raddr(AW'({cmd_q.code, 4'(row_q)})),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			row_q <= '0;
		end else begin
			state_q <= state_d;
			if (pop) row_q <= '0;
			else if (issue && state_q == BK_ROWS) row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (issue_ok) valid_s1 <= issue;
			if (advance) res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= kind_i;
			x_s1 <= x_i;
			y_s1 <= y_i;
			last_s1 <= last_i;
		end
	end

	always_comb begin
		case (kind_s1)
			KIND_GLYPH: mask = rdata;
			KIND_ERASE: mask = 8'hFF;
			default: mask = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q.kind <= kind_s1;
			res_q.pixel_x <= x_s1;
			res_q.pixel_y <= y_s1;
			res_q.pixel_mask <= mask;
			res_q.last <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

@@ sv/text_console_glyph_renderer.sv @@
// Text console glyph renderer. Items enter on the item channel; the front end takes one per
// cycle while its two-entry command queue has room, moves the cursor and queues a command if
// needed. The back end picks up a command when idle, then emits one row per cycle off the font
// RAM read port unless stalled: a printed character or backspace gives GLYPH_HEIGHT rows, a
// character also a clear row on overflow; a font load gives none, newline or return a clear
// row on overflow. The font RAM is not cleared and must be loaded before characters are drawn.
// Registers must be written by the user only while the block is idle; it does not enforce this.
module text_console_glyph_renderer import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic res_valid,
	input logic res_stall,
	output out_item_t res,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [12:0] cfg_wdata
);

	cfg_t cfg_q;
	logic push, q_full, q_valid, q_pop;
	cmd_t push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.screen_width <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLED: cfg_q.enabled <= cfg_wdata[0];
				CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_wdata;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tcgr_front #(
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	tcgr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(head)
	);

	tcgr_back #(
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.head(head),
		.pop(q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("command popped from empty queue");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.op == OP_PRINT && !cfg_q.enabled) |-> !push)
		else $error("character queued while disabled");

	a_clear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_CLEAR) |->
		(res.last && res.pixel_x == '0 && res.pixel_y == '0 && res.pixel_mask == '0))
		else $error("malformed clear transfer");

endmodule
